FILE: hdl/mtss_pkg.sv
// Shared constants, types and tag-name decoder for the markup tag stream scanner.
package mtss_pkg;

  localparam int MAX_TEXT     = 256;
  localparam int MAX_ELEMENTS = 256;
  localparam int TAG_LEN      = 64;

  localparam int TEXT_W = $clog2(MAX_TEXT);
  localparam int ELEM_W = $clog2(MAX_ELEMENTS + 1);
  localparam int TAG_W  = $clog2(TAG_LEN);

  localparam int WORD_CAP = 8;
  localparam int WLEN_W   = $clog2(WORD_CAP + 1);
  localparam int WIDX_W   = $clog2(WORD_CAP);

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_BREAK = 2'd2;
  localparam logic [1:0] KIND_RULE  = 2'd3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] SIZE_BODY = 5'd10;
  localparam logic [4:0] SIZE_BASE = 5'd24;

  // Words are packed first byte in the low bits, unused bytes zero.
  localparam logic [63:0] W_H1      = 64'h0000_0000_0000_3168;
  localparam logic [63:0] W_H2      = 64'h0000_0000_0000_3268;
  localparam logic [63:0] W_H3      = 64'h0000_0000_0000_3368;
  localparam logic [63:0] W_H4      = 64'h0000_0000_0000_3468;
  localparam logic [63:0] W_H5      = 64'h0000_0000_0000_3568;
  localparam logic [63:0] W_H6      = 64'h0000_0000_0000_3668;
  localparam logic [63:0] W_CH1     = 64'h0000_0000_0031_682F;
  localparam logic [63:0] W_CH2     = 64'h0000_0000_0032_682F;
  localparam logic [63:0] W_CH3     = 64'h0000_0000_0033_682F;
  localparam logic [63:0] W_CH4     = 64'h0000_0000_0034_682F;
  localparam logic [63:0] W_B       = 64'h0000_0000_0000_0062;
  localparam logic [63:0] W_STRONG  = 64'h0000_676E_6F72_7473;
  localparam logic [63:0] W_CB      = 64'h0000_0000_0000_622F;
  localparam logic [63:0] W_CSTRONG = 64'h0067_6E6F_7274_732F;
  localparam logic [63:0] W_I       = 64'h0000_0000_0000_0069;
  localparam logic [63:0] W_EM      = 64'h0000_0000_0000_6D65;
  localparam logic [63:0] W_CI      = 64'h0000_0000_0000_692F;
  localparam logic [63:0] W_CEM     = 64'h0000_0000_006D_652F;
  localparam logic [63:0] W_BR      = 64'h0000_0000_0000_7262;
  localparam logic [63:0] W_HR      = 64'h0000_0000_0000_7268;

  typedef struct packed {
    logic       set_head;
    logic [2:0] head_val;
    logic       set_bold;
    logic       bold_val;
    logic       set_ital;
    logic       ital_val;
    logic       emit;
    logic [1:0] emit_kind;
  } tag_action_t;

  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] ch;
  } tag_ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [2:0] elem_type;
    logic       is_bold;
    logic       is_italic;
    logic [4:0] size_pt;
  } result_t;

  function automatic tag_action_t tag_decode(input logic [WORD_CAP*8-1:0] word);
    tag_action_t a;
    a = '0;
    a.emit_kind = KIND_TEXT;
    if (word == W_H1) begin
      a.set_head = 1'b1; a.head_val = 3'd1;
    end else if (word == W_H2) begin
      a.set_head = 1'b1; a.head_val = 3'd2;
    end else if (word == W_H3) begin
      a.set_head = 1'b1; a.head_val = 3'd3;
    end else if (word == W_H4 || word == W_H5 || word == W_H6) begin
      a.set_head = 1'b1; a.head_val = 3'd4;
    end else if (word == W_CH1 || word == W_CH2 || word == W_CH3 || word == W_CH4) begin
      a.set_head = 1'b1; a.head_val = 3'd0;
    end else if (word == W_B || word == W_STRONG) begin
      a.set_bold = 1'b1; a.bold_val = 1'b1;
    end else if (word == W_CB || word == W_CSTRONG) begin
      a.set_bold = 1'b1; a.bold_val = 1'b0;
    end else if (word == W_I || word == W_EM) begin
      a.set_ital = 1'b1; a.ital_val = 1'b1;
    end else if (word == W_CI || word == W_CEM) begin
      a.set_ital = 1'b1; a.ital_val = 1'b0;
    end else if (word == W_BR) begin
      a.emit = 1'b1; a.emit_kind = KIND_BREAK;
    end else if (word == W_HR) begin
      a.emit = 1'b1; a.emit_kind = KIND_RULE;
    end
    return a;
  endfunction

endpackage

FILE: hdl/mtss_tag.sv
// Tag word collector: skips leading whitespace, folds case, keeps the first word.
module mtss_tag
  import mtss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tag_ctl_t    ctl,
  output tag_action_t action
);

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_WORD   = 2'd1;
  localparam logic [1:0] PH_AFTER  = 2'd2;

  logic [TAG_W-1:0]        tag_bytes;
  logic [1:0]              word_phase;
  logic [WORD_CAP*8-1:0]   word_store;
  logic [WLEN_W-1:0]       word_len;

  logic       is_space;
  logic [7:0] folded;

  assign is_space = (ctl.ch == CH_SPACE) || (ctl.ch >= 8'h09 && ctl.ch <= CH_CR);
  assign folded   = (ctl.ch >= 8'h41 && ctl.ch <= 8'h5A) ? (ctl.ch | 8'h20) : ctl.ch;
  assign action   = tag_decode(word_store);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      tag_bytes  <= '0;
      word_phase <= PH_BEFORE;
      word_store <= '0;
      word_len   <= '0;
    end else if (ctl.feed && tag_bytes < TAG_W'(TAG_LEN - 1)) begin
      tag_bytes <= tag_bytes + 1'b1;
      if (word_phase != PH_AFTER) begin
        if (ctl.ch == 8'h00) begin
          word_phase <= PH_AFTER;
        end else if (is_space) begin
          if (word_phase == PH_WORD) begin
            word_phase <= PH_AFTER;
          end
        end else begin
          word_phase <= PH_WORD;
          if (word_len < WLEN_W'(WORD_CAP)) begin
            word_store[word_len[WIDX_W-1:0]*8 +: 8] <= folded;
            word_len <= word_len + 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: hdl/mtss_step.sv
// Per-byte element state: tag tracking, style flags, text limits and result selection.
module mtss_step
  import mtss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        func,
  input  logic [7:0]  ch,
  input  tag_action_t action,
  output tag_ctl_t    tag_ctl,
  output logic        res_valid,
  output result_t     res
);

  logic              inside_tag, inside_tag_next;
  logic [2:0]        heading_level, heading_level_next;
  logic              bold_on, bold_on_next;
  logic              italic_on, italic_on_next;
  logic [TEXT_W-1:0] text_bytes, text_bytes_next;
  logic              text_cut, text_cut_next;
  logic [ELEM_W-1:0] element_count, element_count_next;

  logic       elem_ok;
  logic       head_on;
  logic [7:0] mapped;

  assign elem_ok = element_count < ELEM_W'(MAX_ELEMENTS);
  assign head_on = heading_level != 3'd0;
  assign mapped  = (ch == CH_LF || ch == CH_CR) ? CH_SPACE : ch;

  always_comb begin
    inside_tag_next    = inside_tag;
    heading_level_next = heading_level;
    bold_on_next       = bold_on;
    italic_on_next     = italic_on;
    text_bytes_next    = text_bytes;
    text_cut_next      = text_cut;
    element_count_next = element_count;
    tag_ctl            = '0;
    tag_ctl.ch         = ch;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = KIND_TEXT;
    res.size_pt        = SIZE_BODY;

    if (func) begin
      // end of document: flush pending text as a plain paragraph, then reset
      if (text_bytes != '0 && elem_ok) begin
        res_valid     = 1'b1;
        res.kind      = KIND_CLOSE;
        res.is_bold   = bold_on;
        res.is_italic = italic_on;
      end
      inside_tag_next    = 1'b0;
      heading_level_next = 3'd0;
      bold_on_next       = 1'b0;
      italic_on_next     = 1'b0;
      text_bytes_next    = '0;
      text_cut_next      = 1'b0;
      element_count_next = '0;
      tag_ctl.clear      = 1'b1;
    end else if (ch == CH_LT) begin
      if (text_bytes != '0) begin
        if (elem_ok) begin
          res_valid          = 1'b1;
          res.kind           = KIND_CLOSE;
          res.elem_type      = heading_level;
          res.is_bold        = bold_on | head_on;
          res.is_italic      = italic_on;
          res.size_pt        = head_on ? (SIZE_BASE - {1'b0, heading_level, 1'b0})
                                       : SIZE_BODY;
          element_count_next = element_count + 1'b1;
        end
        text_bytes_next = '0;
        text_cut_next   = 1'b0;
      end
      inside_tag_next = 1'b1;
      tag_ctl.clear   = 1'b1;
    end else if (ch == CH_GT && inside_tag) begin
      inside_tag_next = 1'b0;
      if (action.set_head) heading_level_next = action.head_val;
      if (action.set_bold) bold_on_next = action.bold_val;
      if (action.set_ital) italic_on_next = action.ital_val;
      if (action.emit && elem_ok) begin
        res_valid          = 1'b1;
        res.kind           = action.emit_kind;
        element_count_next = element_count + 1'b1;
      end
      tag_ctl.clear = 1'b1;
    end else if (inside_tag) begin
      tag_ctl.feed = 1'b1;
    end else if (text_bytes < TEXT_W'(MAX_TEXT - 1)) begin
      text_bytes_next = text_bytes + 1'b1;
      if (mapped == 8'h00) begin
        text_cut_next = 1'b1;
      end else if (!text_cut && elem_ok) begin
        res_valid    = 1'b1;
        res.out_char = mapped;
      end
    end

    if (!fire) begin
      tag_ctl.clear = 1'b0;
      tag_ctl.feed  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag    <= 1'b0;
      heading_level <= 3'd0;
      bold_on       <= 1'b0;
      italic_on     <= 1'b0;
      text_bytes    <= '0;
      text_cut      <= 1'b0;
      element_count <= '0;
    end else if (fire) begin
      inside_tag    <= inside_tag_next;
      heading_level <= heading_level_next;
      bold_on       <= bold_on_next;
      italic_on     <= italic_on_next;
      text_bytes    <= text_bytes_next;
      text_cut      <= text_cut_next;
      element_count <= element_count_next;
    end
  end

endmodule

FILE: hdl/markup_tag_stream_scanner.sv
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle unless stalled; the input register and the result
// register advance together, so a stalled result holds the input register and no more.
// Requests that give no result still pass through the input register.
// Reset (rst, synchronous) clears the element state, tag word and both valid flags.
// Top level: input register, per-byte step logic and result register.
module markup_tag_stream_scanner
  import mtss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_char,
  output logic [2:0] elem_type,
  output logic       is_bold,
  output logic       is_italic,
  output logic [4:0] size_pt
);

  logic        in_full;
  logic        in_func;
  logic [7:0]  in_ch;
  logic        adv;
  logic        fire;
  tag_ctl_t    tag_ctl;
  tag_action_t action;
  logic        res_valid;
  result_t     res;

  assign adv      = !out_valid || !out_stall;
  assign fire     = in_full && adv;
  assign in_stall = in_full && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_func <= func;
      in_ch   <= ch;
    end
  end

  mtss_tag u_tag (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tag_ctl),
    .action (action)
  );

  mtss_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .func      (in_func),
    .ch        (in_ch),
    .action    (action),
    .tag_ctl   (tag_ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      kind      <= res.kind;
      out_char  <= res.out_char;
      elem_type <= res.elem_type;
      is_bold   <= res.is_bold;
      is_italic <= res.is_italic;
      size_pt   <= res.size_pt;
    end
  end

endmodule

FILE: hdl/mtss_check.sv
// Port-level checker for the markup tag stream scanner, bound to the top level.
module mtss_check
  import mtss_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] out_char,
  input logic [2:0] elem_type,
  input logic       is_bold,
  input logic       is_italic,
  input logic [4:0] size_pt
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result valid or input stalled after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_char)
      && $stable(size_pt))
    else $error("stalled result changed");

  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TEXT |-> out_char != 8'h00 && out_char != CH_LF
      && out_char != CH_CR && elem_type == 3'd0 && !is_bold && !is_italic
      && size_pt == SIZE_BODY)
    else $error("bad text byte result");

  a_close_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CLOSE |-> elem_type <= 3'd4 && out_char == 8'h00
      && size_pt == ((elem_type == 3'd0) ? SIZE_BODY
                                         : (SIZE_BASE - {1'b0, elem_type, 1'b0})))
    else $error("close size does not follow heading level");

  a_mark_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_BREAK || kind == KIND_RULE) |-> out_char == 8'h00
      && elem_type == 3'd0 && !is_bold && !is_italic && size_pt == SIZE_BODY)
    else $error("bad break or rule result");

endmodule

bind markup_tag_stream_scanner mtss_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .out_char  (out_char),
  .elem_type (elem_type),
  .is_bold   (is_bold),
  .is_italic (is_italic),
  .size_pt   (size_pt)
);

FILE: dv/markup_tag_stream_scanner_test.sv
// Self-checking testbench for the markup tag stream scanner.
module markup_tag_stream_scanner_test;
  import mtss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit         FUNC_BYTE   = 1'b0;
  localparam bit         FUNC_END    = 1'b1;
  localparam logic [7:0] NUL         = 8'h00;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 130;

  typedef enum logic [1:0] {WORD_WAIT, WORD_IN, WORD_DONE} word_phase_e;

  typedef struct {
    bit         f;
    logic [7:0] c;
  } doc_item_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       func      = FUNC_BYTE;
  logic [7:0] ch        = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [2:0] elem_type;
  logic       is_bold;
  logic       is_italic;
  logic [4:0] size_pt;

  doc_item_t doc_q[$];
  result_t   layout_ops_q[$];
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        err_cnt       = 0;
  int        cycle_cnt     = 0;

  // scanner state as predicted
  bit          in_tag;
  int          tag_cnt;
  word_phase_e wphase;
  logic [7:0]  tag_word[WORD_CAP];
  int          word_n;
  logic [2:0]  head_lvl;
  bit          bold_on;
  bit          ital_on;
  int          txt_cnt;
  bit          txt_cut;
  int          elem_cnt;

  string tag_names[24] = '{"h1", "h2", "h3", "h4", "h5", "h6", "/h1", "/h2", "/h3", "/h4",
                           "/h5", "b", "strong", "/b", "/strong", "i", "em", "/i", "/em",
                           "br", "hr", "p", "strongx", "bb"};

  markup_tag_stream_scanner u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_char  (out_char),
    .elem_type (elem_type),
    .is_bold   (is_bold),
    .is_italic (is_italic),
    .size_pt   (size_pt)
  );

  always #10 clk = ~clk;

  task automatic restart_word();
    tag_cnt = 0;
    wphase  = WORD_WAIT;
    word_n  = 0;
    foreach (tag_word[i]) tag_word[i] = NUL;
  endtask

  task automatic clear_scan_state();
    in_tag   = 1'b0;
    restart_word();
    head_lvl = 3'd0;
    bold_on  = 1'b0;
    ital_on  = 1'b0;
    txt_cnt  = 0;
    txt_cut  = 1'b0;
    elem_cnt = 0;
  endtask

  function automatic bit word_eq(string nm);
    if (nm.len() != word_n) return 1'b0;
    for (int i = 0; i < word_n; i++) begin
      if (tag_word[i] != nm[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predicted scanner by one request and queue its output, if any.
  task automatic scan_doc_byte(input bit f, input logic [7:0] c);
    result_t    r;
    bit         hit;
    logic [1:0] mark;
    logic [7:0] cc;
    r         = '0;
    r.kind    = KIND_TEXT;
    r.size_pt = SIZE_BODY;
    hit       = 1'b0;
    mark      = KIND_TEXT;
    if (f == FUNC_END) begin
      if (txt_cnt > 0 && elem_cnt < MAX_ELEMENTS) begin
        r.kind      = KIND_CLOSE;
        r.is_bold   = bold_on;
        r.is_italic = ital_on;
        hit         = 1'b1;
      end
      clear_scan_state();
    end else if (c == CH_LT) begin
      if (txt_cnt > 0) begin
        if (elem_cnt < MAX_ELEMENTS) begin
          r.kind      = KIND_CLOSE;
          r.elem_type = head_lvl;
          r.is_bold   = bold_on || (head_lvl != 3'd0);
          r.is_italic = ital_on;
          r.size_pt   = (head_lvl != 3'd0) ? SIZE_BASE - 5'(2 * head_lvl) : SIZE_BODY;
          elem_cnt++;
          hit = 1'b1;
        end
        txt_cnt = 0;
        txt_cut = 1'b0;
      end
      in_tag = 1'b1;
      restart_word();
    end else if (c == CH_GT && in_tag) begin
      in_tag = 1'b0;
      if (word_eq("h1")) head_lvl = 3'd1;
      else if (word_eq("h2")) head_lvl = 3'd2;
      else if (word_eq("h3")) head_lvl = 3'd3;
      else if (word_eq("h4") || word_eq("h5") || word_eq("h6")) head_lvl = 3'd4;
      else if (word_eq("/h1") || word_eq("/h2") || word_eq("/h3") || word_eq("/h4"))
        head_lvl = 3'd0;
      else if (word_eq("b") || word_eq("strong")) bold_on = 1'b1;
      else if (word_eq("/b") || word_eq("/strong")) bold_on = 1'b0;
      else if (word_eq("i") || word_eq("em")) ital_on = 1'b1;
      else if (word_eq("/i") || word_eq("/em")) ital_on = 1'b0;
      else if (word_eq("br")) mark = KIND_BREAK;
      else if (word_eq("hr")) mark = KIND_RULE;
      if (mark != KIND_TEXT && elem_cnt < MAX_ELEMENTS) begin
        r.kind = mark;
        elem_cnt++;
        hit = 1'b1;
      end
      restart_word();
    end else if (in_tag) begin
      if (tag_cnt < TAG_LEN - 1) begin
        tag_cnt++;
        if (wphase != WORD_DONE) begin
          if (c == NUL) begin
            wphase = WORD_DONE;
          end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            if (wphase == WORD_IN) wphase = WORD_DONE;
          end else begin
            wphase = WORD_IN;
            if (word_n < WORD_CAP) begin
              tag_word[word_n] = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
              word_n++;
            end
          end
        end
      end
    end else begin
      cc = (c == CH_LF || c == CH_CR) ? CH_SPACE : c;
      if (txt_cnt < MAX_TEXT - 1) begin
        txt_cnt++;
        if (cc == NUL) begin
          txt_cut = 1'b1;
        end else if (!txt_cut && elem_cnt < MAX_ELEMENTS) begin
          r.out_char = cc;
          hit = 1'b1;
        end
      end
    end
    if (hit) layout_ops_q.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] c);
    doc_item_t it;
    it.f = FUNC_BYTE;
    it.c = c;
    doc_q.push_back(it);
  endtask

  task automatic push_end();
    doc_item_t it;
    it.f = FUNC_END;
    it.c = 8'($urandom_range(0, 255));
    doc_q.push_back(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_blank();
    logic [7:0] set[6] = '{CH_SPACE, 8'h09, CH_LF, 8'h0B, 8'h0C, CH_CR};
    return set[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range("a", "z"));
  endfunction

  task automatic gen_text(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) push_byte(($urandom_range(0, 5) == 0) ? CH_SPACE : rand_letter());
      else if (r < 80) push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      else if (r < 83) push_byte(NUL);
      else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // A tag with random case, padding, odd words and trailing attributes.
  task automatic gen_tag(input int pad);
    string      nm;
    int         pick;
    logic [7:0] c;
    push_byte(CH_LT);
    repeat (pad) push_byte(rand_blank());
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      nm = tag_names[$urandom_range(0, 23)];
    end else if (pick < 90) begin
      nm = "";
      repeat ($urandom_range(1, 10)) nm = {nm, "x"};
      for (int i = 0; i < nm.len(); i++) nm.putc(i, rand_letter());
    end else begin
      nm = "";
    end
    for (int i = 0; i < nm.len(); i++) begin
      c = nm[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'h20;
      push_byte(c);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      push_byte(NUL);
      push_str("x");
    end else if (pick < 4) begin
      push_byte(rand_blank());
      repeat ($urandom_range(1, 6)) push_byte(rand_letter());
    end else if (pick == 4) begin
      // restart inside the tag
      push_byte(CH_LT);
      push_str(tag_names[$urandom_range(0, 23)]);
    end
    push_byte(CH_GT);
  endtask

  task automatic gen_doc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      gen_text($urandom_range(1, 4));
      gen_tag($urandom_range(58, 66));
      gen_text($urandom_range(1, 4));
      push_byte(CH_LT);
      push_end();
    end else begin
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 1)) gen_text($urandom_range(1, 15));
        else gen_tag($urandom_range(0, 2));
      end
      if ($urandom_range(0, 99) < 85) push_end();
    end
  endtask

  // text from under to past the per-element byte limit, with formatting active
  task automatic gen_long_text();
    push_str("<i><h2>");
    repeat ($urandom_range(250, 270)) push_byte(rand_letter());
    push_byte(CH_LT);
    push_str("/h2>abc");
    push_end();
  endtask

  // runs the element counter past its limit
  task automatic gen_many_elements();
    repeat ($urandom_range(128, 132)) push_str("x<br>");
    push_str("y<hr>z<");
    push_str("b>w");
    push_end();
  endtask

  always @(posedge clk) begin : drive_proc
    doc_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) scan_doc_byte(func, ch);
      if (!in_valid || !in_stall) begin
        if (doc_q.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          nxt = doc_q.pop_front();
          in_valid <= 1'b1;
          func <= nxt.f;
          ch <= nxt.c;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (layout_ops_q.size() == 0) begin
          $error("unexpected output: kind %0d char %0d", kind, out_char);
          err_cnt++;
        end else begin
          e = layout_ops_q.pop_front();
          cmp_field("kind", 8'(e.kind), 8'(kind));
          cmp_field("out_char", e.out_char, out_char);
          cmp_field("elem_type", 8'(e.elem_type), 8'(elem_type));
          cmp_field("is_bold", 8'(e.is_bold), 8'(is_bold));
          cmp_field("is_italic", 8'(e.is_italic), 8'(is_italic));
          cmp_field("size_pt", 8'(e.size_pt), 8'(size_pt));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("markup_tag_stream_scanner_test: errors");
      $finish;
    end
  end

  initial begin
    int base;
    clear_scan_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // heading fold, CR/LF, zero byte cut, stray '>', restart in tag, empty flush
    push_str("<H6>\n");
    push_byte(8'hFF);
    push_str("</H4>");
    push_byte(NUL);
    push_str("a<br>>");
    push_end();
    push_str("<<hr>");
    push_end();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (ph == 1) gen_long_text();
      if (ph == 2) gen_many_elements();
      base = doc_q.size();
      while (doc_q.size() - base < PHASE_ITEMS) gen_doc();
      push_end();
      // hold the next phase off until every expected output is back
      do @(negedge clk); while (doc_q.size() != 0 || in_valid || layout_ops_q.size() != 0);
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && layout_ops_q.size() == 0)
      $display("markup_tag_stream_scanner_test: clean");
    else
      $display("markup_tag_stream_scanner_test: errors");
    $finish;
  end

endmodule
